>>> sv/ycc_pkg.sv
// ----------------------------------------------------------------------------
// ycc_pkg
// Shared types and constants for the 4:2:2 YCbCr to RGB stream converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ycc_pkg;

  localparam int COEF_W    = 19;
  localparam int BYTE_W    = 8;
  localparam int FRAC_BITS = 16;
  localparam int PROD_W    = COEF_W + BYTE_W + 1;
  localparam int SUM_W     = PROD_W + 2;
  localparam int SHIFT_W   = SUM_W - FRAC_BITS;
  localparam int CFG_IDX_W = 3;

  localparam logic [BYTE_W-1:0] LUMA_OFFSET = 8'd16;
  localparam logic [BYTE_W-1:0] BYTE_MAX    = 8'd255;

  localparam logic signed [COEF_W-1:0] LUMA_GAIN_RST   = 19'sd76284;
  localparam logic signed [COEF_W-1:0] CR_TO_RED_RST   = 19'sd104596;
  localparam logic signed [COEF_W-1:0] CB_TO_GREEN_RST = -19'sd25690;
  localparam logic signed [COEF_W-1:0] CR_TO_GREEN_RST = -19'sd53281;
  localparam logic signed [COEF_W-1:0] CB_TO_BLUE_RST  = 19'sd132186;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LUMA_GAIN   = 3'd0,
    CFG_CR_TO_RED   = 3'd1,
    CFG_CB_TO_GREEN = 3'd2,
    CFG_CR_TO_GREEN = 3'd3,
    CFG_CB_TO_BLUE  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PH_CB = 2'd0,
    PH_Y0 = 2'd1,
    PH_CR = 2'd2,
    PH_Y1 = 2'd3
  } phase_e;

  typedef struct packed {
    logic signed [COEF_W-1:0] luma_gain;
    logic signed [COEF_W-1:0] cr_to_red;
    logic signed [COEF_W-1:0] cb_to_green;
    logic signed [COEF_W-1:0] cr_to_green;
    logic signed [COEF_W-1:0] cb_to_blue;
  } coef_t;

  typedef struct packed {
    logic [BYTE_W-1:0] luma;
    logic [BYTE_W-1:0] cr;
    logic [BYTE_W-1:0] cb;
  } pix_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] base;
    logic signed [PROD_W-1:0] cr_red;
    logic signed [PROD_W-1:0] cb_green;
    logic signed [PROD_W-1:0] cr_green;
    logic signed [PROD_W-1:0] cb_blue;
  } prod_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_t;

endpackage

`default_nettype wire

>>> sv/ycbcr422_to_rgb_stream.sv
// ----------------------------------------------------------------------------
// ycbcr422_to_rgb_stream
// BT.601 YCbCr 4:2:2 byte stream to RGB pixel converter.
//
// Input: one byte per item on in_valid_i / in_stall_o, ordered Cb, Y, Cr, Y
// without framing. Output: one RGB pixel per item on out_valid_o /
// out_stall_i, produced after every Cb or Cr byte except the first one after
// reset. Five signed Q2.16 coefficients are written through cfg_we_i,
// cfg_index_i and cfg_data_i; the user must write them only while the
// stream is idle, as the block itself does not enforce it. Other indexes
// are dropped. Throughput: one byte per cycle while in_stall_o is low.
// A pixel passes from the byte that completes it through the unpack
// register, the product register and the result register.
// Reset clears the byte phase, the held components and all valid bits and
// loads the standard BT.601 coefficients. A stall on the output holds the
// pixel; the three stages fill and then in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module ycbcr422_to_rgb_stream
  import ycc_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [BYTE_W-1:0]    stream_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [BYTE_W-1:0]         red_o,
  output logic [BYTE_W-1:0]         green_o,
  output logic [BYTE_W-1:0]         blue_o,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [COEF_W-1:0]    cfg_data_i
);

  coef_t coef_q, coef_d;
  pix_t  pix;
  prod_t prod;
  rgb_t  rgb;
  logic  in_ready;
  logic  pix_valid, pix_ready;
  logic  prod_valid, prod_ready;

  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_LUMA_GAIN:   coef_d.luma_gain   = $signed(cfg_data_i);
        CFG_CR_TO_RED:   coef_d.cr_to_red   = $signed(cfg_data_i);
        CFG_CB_TO_GREEN: coef_d.cb_to_green = $signed(cfg_data_i);
        CFG_CR_TO_GREEN: coef_d.cr_to_green = $signed(cfg_data_i);
        CFG_CB_TO_BLUE:  coef_d.cb_to_blue  = $signed(cfg_data_i);
        default:         coef_d             = coef_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q.luma_gain   <= LUMA_GAIN_RST;
      coef_q.cr_to_red   <= CR_TO_RED_RST;
      coef_q.cb_to_green <= CB_TO_GREEN_RST;
      coef_q.cr_to_green <= CR_TO_GREEN_RST;
      coef_q.cb_to_blue  <= CB_TO_BLUE_RST;
    end else begin
      coef_q <= coef_d;
    end
  end

  ycc_unpack u_unpack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .byte_i  (stream_byte_i),
    .ready_o (in_ready),
    .valid_o (pix_valid),
    .pix_o   (pix),
    .ready_i (pix_ready)
  );

  ycc_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_valid),
    .pix_i   (pix),
    .coef_i  (coef_q),
    .ready_o (pix_ready),
    .valid_o (prod_valid),
    .prod_o  (prod),
    .ready_i (prod_ready)
  );

  ycc_clamp u_clamp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .prod_i  (prod),
    .ready_o (prod_ready),
    .valid_o (out_valid_o),
    .rgb_o   (rgb),
    .ready_i (!out_stall_i)
  );

  assign in_stall_o = !in_ready;
  assign red_o      = rgb.red;
  assign green_o    = rgb.green;
  assign blue_o     = rgb.blue;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (pix_valid && prod_valid && out_valid_o && out_stall_i))
    else $error("input stalled while the pipeline has room");

  a_pixel_from_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(pix_valid) |-> $past(in_valid_i && !in_stall_o))
    else $error("pixel registered without an accepted byte");

  a_result_from_product: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(prod_valid))
    else $error("result valid without a product in flight");
`endif

endmodule

`default_nettype wire

>>> sv/ycc_unpack.sv
// ----------------------------------------------------------------------------
// ycc_unpack
// Tracks the Cb, Y, Cr, Y byte phase, holds the latest components and
// registers one pixel after every even-phase byte but the first.
// ----------------------------------------------------------------------------
`default_nettype none

module ycc_unpack
  import ycc_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              valid_i,
  input  wire logic [BYTE_W-1:0] byte_i,
  output logic                   ready_o,
  output logic                   valid_o,
  output pix_t                   pix_o,
  input  wire logic              ready_i
);

  phase_e            phase_q, phase_d;
  logic              primed_q, primed_d;
  logic [BYTE_W-1:0] luma_q, luma_d;
  logic [BYTE_W-1:0] cr_q, cr_d;
  logic [BYTE_W-1:0] cb_q, cb_d;
  logic              valid_q, valid_d;
  pix_t              pix_q;
  logic              accept;
  logic              emit;

  assign ready_o = !valid_q || ready_i;
  assign accept  = valid_i && ready_o;

  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      phase_d = phase_e'(phase_q + 2'd1);
    end
  end

  always_comb begin
    primed_d = primed_q;
    luma_d   = luma_q;
    cr_d     = cr_q;
    cb_d     = cb_q;
    emit     = 1'b0;
    if (accept) begin
      unique case (phase_q)
        PH_CB: begin
          cb_d     = byte_i;
          emit     = primed_q;
          primed_d = 1'b1;
        end
        PH_CR: begin
          cr_d     = byte_i;
          emit     = primed_q;
          primed_d = 1'b1;
        end
        PH_Y0, PH_Y1: begin
          luma_d = byte_i;
        end
        default: begin
          luma_d = luma_q;
        end
      endcase
    end
  end

  assign valid_d = ready_o ? (accept && emit) : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_CB;
      primed_q <= 1'b0;
      luma_q   <= '0;
      cr_q     <= '0;
      cb_q     <= '0;
      valid_q  <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      primed_q <= primed_d;
      luma_q   <= luma_d;
      cr_q     <= cr_d;
      cb_q     <= cb_d;
      valid_q  <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && emit) begin
      pix_q.luma <= luma_q;
      pix_q.cr   <= cr_d;
      pix_q.cb   <= cb_d;
    end
  end

  assign valid_o = valid_q;
  assign pix_o   = pix_q;

endmodule

`default_nettype wire

>>> sv/ycc_mult.sv
// ----------------------------------------------------------------------------
// ycc_mult
// Centers the held components and registers the five coefficient products.
// ----------------------------------------------------------------------------
`default_nettype none

module ycc_mult
  import ycc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire pix_t  pix_i,
  input  wire coef_t coef_i,
  output logic       ready_o,
  output logic       valid_o,
  output prod_t      prod_o,
  input  wire logic  ready_i
);

  logic                     valid_q, valid_d;
  logic                     load;
  prod_t                    prod_q, prod_d;
  logic signed [BYTE_W:0]   luma_c;
  logic signed [BYTE_W-1:0] cr_c;
  logic signed [BYTE_W-1:0] cb_c;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    luma_c = $signed({1'b0, pix_i.luma} - {1'b0, LUMA_OFFSET});
    cr_c   = $signed({~pix_i.cr[BYTE_W-1], pix_i.cr[BYTE_W-2:0]});
    cb_c   = $signed({~pix_i.cb[BYTE_W-1], pix_i.cb[BYTE_W-2:0]});
    prod_d.base     = PROD_W'(coef_i.luma_gain)   * PROD_W'(luma_c);
    prod_d.cr_red   = PROD_W'(coef_i.cr_to_red)   * PROD_W'(cr_c);
    prod_d.cb_green = PROD_W'(coef_i.cb_to_green) * PROD_W'(cb_c);
    prod_d.cr_green = PROD_W'(coef_i.cr_to_green) * PROD_W'(cr_c);
    prod_d.cb_blue  = PROD_W'(coef_i.cb_to_blue)  * PROD_W'(cb_c);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign prod_o  = prod_q;

endmodule

`default_nettype wire

>>> sv/ycc_clamp.sv
// ----------------------------------------------------------------------------
// ycc_clamp
// Sums the products per channel, floors by the fraction bits, clamps each
// channel to one byte and holds the pixel in the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ycc_clamp
  import ycc_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  valid_i,
  input  wire prod_t prod_i,
  output logic       ready_o,
  output logic       valid_o,
  output rgb_t       rgb_o,
  input  wire logic  ready_i
);

  logic                    valid_q, valid_d;
  logic                    load;
  rgb_t                    rgb_q, rgb_d;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [SUM_W-1:0] sum_g;
  logic signed [SUM_W-1:0] sum_b;

  function automatic logic [BYTE_W-1:0] to_byte(input logic signed [SUM_W-1:0] s);
    logic signed [SHIFT_W-1:0] f;
    f = $signed(s[SUM_W-1:FRAC_BITS]);
    if (f < 0) begin
      to_byte = '0;
    end else if (f > $signed({{(SHIFT_W-BYTE_W){1'b0}}, BYTE_MAX})) begin
      to_byte = BYTE_MAX;
    end else begin
      to_byte = f[BYTE_W-1:0];
    end
  endfunction

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;
  assign valid_d = ready_o ? valid_i : valid_q;

  always_comb begin
    sum_r = SUM_W'(prod_i.base) + SUM_W'(prod_i.cr_red);
    sum_g = SUM_W'(prod_i.base) + SUM_W'(prod_i.cb_green) + SUM_W'(prod_i.cr_green);
    sum_b = SUM_W'(prod_i.base) + SUM_W'(prod_i.cb_blue);
    rgb_d.red   = to_byte(sum_r);
    rgb_d.green = to_byte(sum_g);
    rgb_d.blue  = to_byte(sum_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      rgb_q <= rgb_d;
    end
  end

  assign valid_o = valid_q;
  assign rgb_o   = rgb_q;

endmodule

`default_nettype wire
